// ----- hdl/sm83_alu_with_flags_unit_assert.svh -----
// ----------------------------------------------------------------------------
// SM83 ALU assertion macros
// Shared concurrent assertion forms for the SM83 execution unit.
// ----------------------------------------------------------------------------
`ifndef SM83_ALU_WITH_FLAGS_UNIT_ASSERT_SVH
`define SM83_ALU_WITH_FLAGS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SM83_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SM83_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sm83alu_pkg.sv -----
// ----------------------------------------------------------------------------
// SM83 ALU package
// Operation codes, flag positions, constants and stage payload types.
// ----------------------------------------------------------------------------
package sm83alu_pkg;

  localparam int OP_W   = 5;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int FLAG_W = 4;

  localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
  localparam logic [OP_W-1:0] OP_ADC   = 5'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
  localparam logic [OP_W-1:0] OP_SBC   = 5'd3;
  localparam logic [OP_W-1:0] OP_AND   = 5'd4;
  localparam logic [OP_W-1:0] OP_XOR   = 5'd5;
  localparam logic [OP_W-1:0] OP_OR    = 5'd6;
  localparam logic [OP_W-1:0] OP_CP    = 5'd7;
  localparam logic [OP_W-1:0] OP_INC8  = 5'd8;
  localparam logic [OP_W-1:0] OP_DEC8  = 5'd9;
  localparam logic [OP_W-1:0] OP_RLCA  = 5'd10;
  localparam logic [OP_W-1:0] OP_RLA   = 5'd11;
  localparam logic [OP_W-1:0] OP_RRCA  = 5'd12;
  localparam logic [OP_W-1:0] OP_RRA   = 5'd13;
  localparam logic [OP_W-1:0] OP_DAA   = 5'd14;
  localparam logic [OP_W-1:0] OP_SCF   = 5'd15;
  localparam logic [OP_W-1:0] OP_CPL   = 5'd16;
  localparam logic [OP_W-1:0] OP_CCF   = 5'd17;
  localparam logic [OP_W-1:0] OP_ADD16 = 5'd18;
  localparam logic [OP_W-1:0] OP_SPOFS = 5'd19;
  localparam logic [OP_W-1:0] OP_INC16 = 5'd20;
  localparam logic [OP_W-1:0] OP_DEC16 = 5'd21;

  // Flag bit positions.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_CORR_LO = 8'h06;
  localparam logic [7:0] DAA_CORR_HI = 8'h60;
  localparam logic [7:0] DAA_HI_MAX  = 8'h99;
  localparam logic [3:0] DAA_LO_MAX  = 4'h9;

  // Stage 1 to stage 2: operands plus decoded carry-in and DAA correction.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [FLAG_W-1:0] f;
    logic              cin8;
    logic [BYTE_W-1:0] daa_corr;
    logic              daa_hi;
    logic [WORD_W-1:0] y_sext;
  } s1_t;

  // Stage 2 to stage 3: adder and subtractor outputs.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [FLAG_W-1:0] f;
    logic              daa_hi;
    logic [BYTE_W:0]   add9;
    logic              add_h;
    logic [BYTE_W:0]   sub9;
    logic              sub_h;
    logic [BYTE_W-1:0] daa8;
    logic [WORD_W:0]   add17;
    logic              h16;
    logic [WORD_W-1:0] sp16;
    logic              sp_h;
    logic              sp_c;
    logic [WORD_W-1:0] inc16;
    logic [WORD_W-1:0] dec16;
  } s2_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [WORD_W-1:0] result;
  } res_t;

endpackage

// ----- hdl/sm83alu_dec.sv -----
// ----------------------------------------------------------------------------
// SM83 ALU decode stage
// Registers the operands, decodes the carry-in and the DAA correction.
// ----------------------------------------------------------------------------
module sm83alu_dec (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sm83alu_pkg::OP_W-1:0]         op,
  input  logic [sm83alu_pkg::WORD_W-1:0]       x,
  input  logic [sm83alu_pkg::WORD_W-1:0]       y,
  input  logic [sm83alu_pkg::FLAG_W-1:0]       f,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sm83alu_pkg::s1_t                     out_data
);

  logic             valid_r, valid_nxt;
  sm83alu_pkg::s1_t data_r, data_nxt;
  logic             adj_lo, adj_hi;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Subtract mode suppresses the range checks on the digits.
  always_comb begin
    adj_lo = f[sm83alu_pkg::FLAG_H] ||
             (!f[sm83alu_pkg::FLAG_N] && (x[3:0] > sm83alu_pkg::DAA_LO_MAX));
    adj_hi = f[sm83alu_pkg::FLAG_C] ||
             (!f[sm83alu_pkg::FLAG_N] && (x[7:0] > sm83alu_pkg::DAA_HI_MAX));
    data_nxt.op       = op;
    data_nxt.x        = x;
    data_nxt.y        = y;
    data_nxt.f        = f;
    data_nxt.cin8     = (op inside {sm83alu_pkg::OP_ADC, sm83alu_pkg::OP_SBC}) &&
                        f[sm83alu_pkg::FLAG_C];
    data_nxt.daa_corr = (adj_lo ? sm83alu_pkg::DAA_CORR_LO : 8'h00) |
                        (adj_hi ? sm83alu_pkg::DAA_CORR_HI : 8'h00);
    data_nxt.daa_hi   = adj_hi;
    data_nxt.y_sext   = {{8{y[7]}}, y[7:0]};
  end

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/sm83alu_exe.sv -----
// ----------------------------------------------------------------------------
// SM83 ALU arithmetic stage
// Runs the 8-bit and 16-bit adders, subtractor and DAA adjust.
// ----------------------------------------------------------------------------
module sm83alu_exe (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sm83alu_pkg::s1_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sm83alu_pkg::s2_t out_data
);

  logic             valid_r, valid_nxt;
  sm83alu_pkg::s2_t data_r, data_nxt;
  logic [7:0]       a, v;
  logic [4:0]       add5, sub5, sp5;
  logic [12:0]      add13;
  logic [8:0]       sp9;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    a     = in_data.x[7:0];
    v     = in_data.y[7:0];
    add5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, in_data.cin8};
    // A negative nibble difference shows up as bit 4, which is the borrow.
    sub5  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, in_data.cin8};
    add13 = {1'b0, in_data.x[11:0]} + {1'b0, in_data.y[11:0]};
    sp5   = {1'b0, in_data.x[3:0]} + {1'b0, v[3:0]};
    sp9   = {1'b0, in_data.x[7:0]} + {1'b0, v};

    data_nxt.op     = in_data.op;
    data_nxt.x      = in_data.x;
    data_nxt.y      = in_data.y;
    data_nxt.f      = in_data.f;
    data_nxt.daa_hi = in_data.daa_hi;
    data_nxt.add9   = {1'b0, a} + {1'b0, v} + {8'd0, in_data.cin8};
    data_nxt.add_h  = add5[4];
    data_nxt.sub9   = {1'b0, a} - {1'b0, v} - {8'd0, in_data.cin8};
    data_nxt.sub_h  = sub5[4];
    data_nxt.daa8   = in_data.f[sm83alu_pkg::FLAG_N] ? (a - in_data.daa_corr)
                                                     : (a + in_data.daa_corr);
    data_nxt.add17  = {1'b0, in_data.x} + {1'b0, in_data.y};
    data_nxt.h16    = add13[12];
    data_nxt.sp16   = in_data.x + in_data.y_sext;
    data_nxt.sp_h   = sp5[4];
    data_nxt.sp_c   = sp9[8];
    data_nxt.inc16  = in_data.x + 16'd1;
    data_nxt.dec16  = in_data.x - 16'd1;
  end

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/sm83alu_wb.sv -----
// ----------------------------------------------------------------------------
// SM83 ALU result stage
// Selects the result by operation, forms the flags and holds the output item.
// ----------------------------------------------------------------------------
module sm83alu_wb (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sm83alu_pkg::s2_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sm83alu_pkg::res_t out_data
);

  logic              valid_r, valid_nxt;
  sm83alu_pkg::res_t data_r, data_nxt;
  logic [7:0]        a, v, r8;
  logic              fz, fn, fh, fc, cin;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    a   = in_data.x[7:0];
    v   = in_data.y[7:0];
    cin = in_data.f[sm83alu_pkg::FLAG_C];
    r8  = 8'h00;
    fz  = in_data.f[sm83alu_pkg::FLAG_Z];
    fn  = in_data.f[sm83alu_pkg::FLAG_N];
    fh  = in_data.f[sm83alu_pkg::FLAG_H];
    fc  = cin;
    data_nxt.result = in_data.x;
    case (in_data.op)
      sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
        r8 = in_data.add9[7:0];
        data_nxt.result = {8'h00, r8};
        fz = (r8 == 8'h00);
        fn = 1'b0;
        fh = in_data.add_h;
        fc = in_data.add9[8];
      end
      sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
        r8 = in_data.sub9[7:0];
        // Compare keeps the accumulator but flags the difference.
        data_nxt.result = (in_data.op == sm83alu_pkg::OP_CP) ? {8'h00, a} : {8'h00, r8};
        fz = (r8 == 8'h00);
        fn = 1'b1;
        fh = in_data.sub_h;
        fc = in_data.sub9[8];
      end
      sm83alu_pkg::OP_AND, sm83alu_pkg::OP_XOR, sm83alu_pkg::OP_OR: begin
        case (in_data.op)
          sm83alu_pkg::OP_AND: r8 = a & v;
          sm83alu_pkg::OP_XOR: r8 = a ^ v;
          default:             r8 = a | v;
        endcase
        data_nxt.result = {8'h00, r8};
        fz = (r8 == 8'h00);
        fn = 1'b0;
        fh = (in_data.op == sm83alu_pkg::OP_AND);
        fc = 1'b0;
      end
      sm83alu_pkg::OP_INC8: begin
        r8 = in_data.inc16[7:0];
        data_nxt.result = {8'h00, r8};
        fz = (r8 == 8'h00);
        fn = 1'b0;
        fh = (a[3:0] == 4'hF);
      end
      sm83alu_pkg::OP_DEC8: begin
        r8 = in_data.dec16[7:0];
        data_nxt.result = {8'h00, r8};
        fz = (r8 == 8'h00);
        fn = 1'b1;
        fh = (a[3:0] == 4'h0);
      end
      sm83alu_pkg::OP_RLCA, sm83alu_pkg::OP_RLA,
      sm83alu_pkg::OP_RRCA, sm83alu_pkg::OP_RRA: begin
        case (in_data.op)
          sm83alu_pkg::OP_RLCA: r8 = {a[6:0], a[7]};
          sm83alu_pkg::OP_RLA:  r8 = {a[6:0], cin};
          sm83alu_pkg::OP_RRCA: r8 = {a[0], a[7:1]};
          default:              r8 = {cin, a[7:1]};
        endcase
        data_nxt.result = {8'h00, r8};
        fz = 1'b0;
        fn = 1'b0;
        fh = 1'b0;
        fc = (in_data.op == sm83alu_pkg::OP_RLCA || in_data.op == sm83alu_pkg::OP_RLA) ?
             a[7] : a[0];
      end
      sm83alu_pkg::OP_DAA: begin
        r8 = in_data.daa8;
        data_nxt.result = {8'h00, r8};
        fz = (r8 == 8'h00);
        fh = 1'b0;
        fc = in_data.daa_hi || cin;
      end
      sm83alu_pkg::OP_SCF: begin
        data_nxt.result = {8'h00, a};
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b1;
      end
      sm83alu_pkg::OP_CPL: begin
        data_nxt.result = {8'h00, ~a};
        fn = 1'b1;
        fh = 1'b1;
      end
      sm83alu_pkg::OP_CCF: begin
        data_nxt.result = {8'h00, a};
        fn = 1'b0;
        fh = 1'b0;
        fc = !cin;
      end
      sm83alu_pkg::OP_ADD16: begin
        data_nxt.result = in_data.add17[15:0];
        fn = 1'b0;
        fh = in_data.h16;
        fc = in_data.add17[16];
      end
      sm83alu_pkg::OP_SPOFS: begin
        data_nxt.result = in_data.sp16;
        fz = 1'b0;
        fn = 1'b0;
        fh = in_data.sp_h;
        fc = in_data.sp_c;
      end
      sm83alu_pkg::OP_INC16: begin
        data_nxt.result = in_data.inc16;
      end
      sm83alu_pkg::OP_DEC16: begin
        data_nxt.result = in_data.dec16;
      end
      default: begin
        data_nxt.result = in_data.x;
      end
    endcase
    data_nxt.flags = {fz, fn, fh, fc};
  end

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/sm83_alu_with_flags_unit.sv -----
// ----------------------------------------------------------------------------
// SM83 ALU with flags
// Three-stage pipelined execution unit: 8-bit ALU, rotates, DAA, flag ops,
// 16-bit adds and increments; all but INC16/DEC16 update the Z/N/H/C flags.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one operation per item: the operation code on
//   in_tuser, and the two 16-bit operands and the incoming flags on in_tdata.
//   The output channel returns one item per input item, in order: the 16-bit
//   result and the new flags on out_tdata.
//   An accepted item passes the decode, adder and result registers in turn
//   before out_tvalid rises. Throughput is one item per cycle; the three
//   register stages (decode, adders, result select) each hold one item, so a
//   new item enters every cycle while the output side keeps up.
//   Each stage advances whenever it is empty or the stage after it advances,
//   so a stall by the receiver fills the bubbles first and drops in_tready
//   only once all three stages hold items. No item is lost or repeated.
//   A synchronous reset (rst_n low) empties all stages; payload registers
//   are not cleared. The unit keeps no state between items.
// ----------------------------------------------------------------------------
`include "sm83_alu_with_flags_unit_assert.svh"

module sm83_alu_with_flags_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [35:32] flags_in, [31:16] second_operand, [15:0] first_operand,
  // [39:36] zero fill.
  input  logic [39:0] in_tdata,
  // [4:0] op.
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [19:16] flags_out, [15:0] result, [23:20] zero fill.
  output logic [23:0] out_tdata
);

  sm83alu_pkg::s1_t  s1_data;
  sm83alu_pkg::s2_t  s2_data;
  sm83alu_pkg::res_t res_data;
  logic              s1_valid, s1_ready;
  logic              s2_valid, s2_ready;

  // Stage 1: operand register, carry-in and DAA correction decode.
  sm83alu_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .op        (in_tuser),
    .x         (in_tdata[15:0]),
    .y         (in_tdata[31:16]),
    .f         (in_tdata[35:32]),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // Stage 2: all adders and the subtractor run in parallel.
  sm83alu_exe u_exe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // Stage 3: result selection and flag forming; its register is the output.
  sm83alu_wb u_wb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_data)
  );

  assign out_tdata = {4'h0, res_data.flags, res_data.result};

  // An accepted item is always captured by the first stage.
  `SM83_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_tvalid && in_tready, s1_valid,
                    "accepted item missing from stage 1")
  // Back pressure reaches the input only when every stage is full and blocked.
  `SM83_ASSERT_NOW(a_stall_only_full, clk, rst_n, !in_tready,
                   s1_valid && s2_valid && out_tvalid && !out_tready,
                   "input stalled while the pipeline has room")
  // A blocked middle stage keeps its item.
  `SM83_ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_valid && !s2_ready, s2_valid,
                    "stage 2 item dropped while blocked")
  // With nothing behind it, a taken output item leaves the output empty.
  `SM83_ASSERT_NEXT(a_out_drain, clk, rst_n, out_tvalid && out_tready && !s2_valid,
                    !out_tvalid, "output item repeated")

endmodule
